// ===== sv/pfdp_pkg.sv =====
// shared types, constants and band lookup for the pll divider planner
package pfdp_pkg;

  typedef struct packed {
    logic [22:0] freq_khz;
    logic        int_mode;
  } pfdp_in_t;

  typedef struct packed {
    logic        range_error;
    logic [2:0]  out_div_exp;
    logic [7:0]  int_divider;
    logic [11:0] frac_value;
    logic        int_flag;
    logic        cp_linearity;
    logic        lock_detect_fn;
    logic        frac_one_bit;
    logic [22:0] achieved_khz;
  } pfdp_out_t;

  // per-transaction control carried down the pipeline
  typedef struct packed {
    logic       err;
    logic [2:0] e;
    logic       im;
  } pfdp_ctx_t;

  // accept edge to the edge that samples out_valid high
  localparam int unsigned LATENCY = 11;

  localparam logic [22:0] MIN_KHZ   = 23'd23500;
  localparam logic [22:0] MAX_KHZ   = 23'd6000000;
  localparam logic [15:0] COMP_KHZ  = 16'd38400;
  localparam logic [15:0] HALF_COMP = 16'd19200;
  localparam logic [11:0] FRAC_MOD  = 12'd4095;
  localparam logic [6:0]  DIV_75    = 7'd75;
  // (2^20 - 1) / 75, floor of x / 75 comes out exact or one low
  localparam logic [13:0] RECIP_75  = 14'd13981;
  // floor(2^30 / 4095), used with a 2^21 shift
  localparam logic [18:0] RECIP_FRAC = 19'd262208;
  localparam logic [7:0]  N_MIN     = 8'd78;
  localparam logic [7:0]  N_MAX     = 8'd156;

  localparam logic [22:0] BAND_FLOOR [8] = '{
    23'd3000000, 23'd1500000, 23'd750000, 23'd375000,
    23'd187500,  23'd93750,   23'd46875,  23'd23500
  };

  // smallest band index whose floor the request reaches
  function automatic logic [2:0] band_exp(input logic [22:0] f);
    logic [2:0] e;
    e = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (f >= BAND_FLOOR[i]) e = 3'(i);
    end
    return e;
  endfunction

endpackage

// ===== sv/pll_frequency_divider_plan_top.sv =====
// pll divider planner: band select, divide by comparison frequency, fraction, achieved freq
//
// usage
//   drive in_data and raise start; the transaction is taken at a rising edge
//   where start is high and busy is low. busy is high only during and right
//   after reset, so a new transaction can be taken every cycle.
//   each transaction gives exactly one result: out_data is valid for one
//   cycle with out_valid high, and the receiver takes it at the edge ending
//   that cycle. the receiver cannot stall, and the block never needs it to.
// timing
//   eleven-stage pipeline; throughput is one result per cycle. the stage
//   count comes from the three divide-by-constant units (reciprocal
//   multiply, then one compare-and-correct stage each) and the fraction
//   rescale, one multiplier per stage.
// reset
//   synchronous active-low rst_n empties the pipeline and drops out_valid;
//   transactions in flight are lost. busy stays high until the first edge
//   after rst_n is released.
// out-of-band requests give range_error with all other fields zero
module pll_frequency_divider_plan_top
  import pfdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  pfdp_in_t  in_data,
  output logic      out_valid,
  output pfdp_out_t out_data
);

  logic        busy_r;
  logic [10:1] vld_r;
  logic        out_valid_r;
  pfdp_out_t   out_data_r;
  pfdp_out_t   out_data_nxt;

  // stage 1: input register
  pfdp_in_t    in_r;

  // stage 2: band select
  pfdp_ctx_t   ctx2_r;
  logic [22:0] vco2_r;
  pfdp_ctx_t   ctx2_nxt;
  logic [22:0] vco2_nxt;

  // stage 3: quotient estimate
  pfdp_ctx_t   ctx3_r;
  logic [22:0] vco3_r;
  logic [7:0]  n0_3_r;
  logic [27:0] p3;

  // stage 4: quotient correction
  pfdp_ctx_t   ctx4_r;
  logic [7:0]  n4_r;
  logic [15:0] rem4_r;
  logic [22:0] np4_r;
  logic [23:0] np0;
  logic [23:0] rem0;
  logic [7:0]  n4_nxt;
  logic [15:0] rem4_nxt;
  logic [23:0] np4_nxt;

  // stage 5: scaled remainder
  pfdp_ctx_t   ctx5_r;
  logic [7:0]  n5_r;
  logic [22:0] np5_r;
  logic [27:0] t5_r;
  logic [27:0] t5_nxt;

  // stage 6: fraction estimate
  pfdp_ctx_t   ctx6_r;
  logic [7:0]  n6_r;
  logic [22:0] np6_r;
  logic [18:0] y6_r;
  logic [11:0] q6_r;
  logic [18:0] y6_nxt;
  logic [31:0] p6;

  // stage 7: fraction correction
  pfdp_ctx_t   ctx7_r;
  logic [7:0]  n7_r;
  logic [22:0] np7_r;
  logic [11:0] fr7_r;
  logic [18:0] qm7;
  logic [18:0] r7;
  logic [11:0] fr7_nxt;

  // stage 8: fraction times 75
  pfdp_ctx_t   ctx8_r;
  logic [7:0]  n8_r;
  logic [22:0] np8_r;
  logic [11:0] fr8_r;
  logic [18:0] w8_r;

  // stage 9: fraction contribution estimate
  pfdp_ctx_t   ctx9_r;
  logic [7:0]  n9_r;
  logic [22:0] np9_r;
  logic [11:0] fr9_r;
  logic [18:0] w9_r;
  logic [15:0] g9_r;
  logic [37:0] p9;

  // stage 10: fraction contribution correction
  pfdp_ctx_t   ctx10_r;
  logic [7:0]  n10_r;
  logic [22:0] np10_r;
  logic [11:0] fr10_r;
  logic [15:0] g10_r;
  logic [27:0] gm10;
  logic [27:0] r10;
  logic [15:0] g10_nxt;

  // output stage
  logic [23:0] sum11;
  logic [23:0] sh11;

  logic        accept;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      vld_r       <= {vld_r[9:1], accept};
      out_valid_r <= vld_r[10];
    end
  end

  // stage 2
  always_comb begin
    ctx2_nxt.err = (in_r.freq_khz < MIN_KHZ) || (in_r.freq_khz >= MAX_KHZ);
    ctx2_nxt.e   = band_exp(in_r.freq_khz);
    ctx2_nxt.im  = in_r.int_mode;
    vco2_nxt     = in_r.freq_khz << ctx2_nxt.e;
  end

  // stage 3: floor(vco / 38400) = floor((vco >> 9) / 75), estimate may be one low
  assign p3 = {14'b0, vco2_r[22:9]} * {14'b0, RECIP_75};

  // stage 4
  always_comb begin
    np0  = {16'b0, n0_3_r} * {8'b0, COMP_KHZ};
    rem0 = {1'b0, vco3_r} - np0;
    if (rem0 >= {8'b0, COMP_KHZ}) begin
      n4_nxt   = n0_3_r + 8'd1;
      rem4_nxt = 16'(rem0 - {8'b0, COMP_KHZ});
      np4_nxt  = np0 + {8'b0, COMP_KHZ};
    end else begin
      n4_nxt   = n0_3_r;
      rem4_nxt = rem0[15:0];
      np4_nxt  = np0;
    end
  end

  // stage 5: rem * 4095 + 19200, then divide by 38400 rounds half up
  assign t5_nxt = {12'b0, rem4_r} * {16'b0, FRAC_MOD} + {12'b0, HALF_COMP};

  // stage 6
  assign y6_nxt = t5_r[27:9];
  assign p6     = {13'b0, y6_nxt} * {18'b0, RECIP_75};

  // stage 7
  always_comb begin
    qm7 = {7'b0, q6_r} * {12'b0, DIV_75};
    r7  = y6_r - qm7;
    if (r7 >= {12'b0, DIV_75}) begin
      fr7_nxt = q6_r + 12'd1;
    end else begin
      fr7_nxt = q6_r;
    end
  end

  // stage 9: floor(fr * 38400 / 4095) = floor(w * 512 / 4095), estimate may be one low
  assign p9 = {19'b0, w8_r} * {19'b0, RECIP_FRAC};

  // stage 10
  always_comb begin
    gm10 = {12'b0, g9_r} * {16'b0, FRAC_MOD};
    r10  = {w9_r, 9'b0} - gm10;
    if (r10 >= {16'b0, FRAC_MOD}) begin
      g10_nxt = g9_r + 16'd1;
    end else begin
      g10_nxt = g9_r;
    end
  end

  // output stage
  always_comb begin
    if (ctx10_r.im) begin
      sum11 = {1'b0, np10_r};
    end else begin
      sum11 = {1'b0, np10_r} + {8'b0, g10_r};
    end
    sh11 = sum11 >> ctx10_r.e;
    out_data_nxt = '0;
    if (ctx10_r.err) begin
      out_data_nxt.range_error = 1'b1;
    end else begin
      out_data_nxt.out_div_exp    = ctx10_r.e;
      out_data_nxt.int_divider    = n10_r;
      out_data_nxt.frac_value     = fr10_r;
      out_data_nxt.int_flag       = ctx10_r.im;
      out_data_nxt.cp_linearity   = !ctx10_r.im;
      out_data_nxt.lock_detect_fn = ctx10_r.im;
      out_data_nxt.frac_one_bit   = !ctx10_r.im;
      out_data_nxt.achieved_khz   = sh11[22:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    in_r    <= in_data;

    ctx2_r  <= ctx2_nxt;
    vco2_r  <= vco2_nxt;

    ctx3_r  <= ctx2_r;
    vco3_r  <= vco2_r;
    n0_3_r  <= p3[27:20];

    ctx4_r  <= ctx3_r;
    n4_r    <= n4_nxt;
    rem4_r  <= rem4_nxt;
    np4_r   <= np4_nxt[22:0];

    ctx5_r  <= ctx4_r;
    n5_r    <= n4_r;
    np5_r   <= np4_r;
    t5_r    <= t5_nxt;

    ctx6_r  <= ctx5_r;
    n6_r    <= n5_r;
    np6_r   <= np5_r;
    y6_r    <= y6_nxt;
    q6_r    <= p6[31:20];

    ctx7_r  <= ctx6_r;
    n7_r    <= n6_r;
    np7_r   <= np6_r;
    fr7_r   <= fr7_nxt;

    ctx8_r  <= ctx7_r;
    n8_r    <= n7_r;
    np8_r   <= np7_r;
    fr8_r   <= fr7_r;
    w8_r    <= {7'b0, fr7_r} * {12'b0, DIV_75};

    ctx9_r  <= ctx8_r;
    n9_r    <= n8_r;
    np9_r   <= np8_r;
    fr9_r   <= fr8_r;
    w9_r    <= w8_r;
    g9_r    <= p9[36:21];

    ctx10_r <= ctx9_r;
    n10_r   <= n9_r;
    np10_r  <= np9_r;
    fr10_r  <= fr9_r;
    g10_r   <= g10_nxt;

    out_data_r <= out_data_nxt;
  end

  // every taken transaction comes out after the fixed pipeline latency
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after pipeline latency");

  // out-of-band results carry nothing but the error flag
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.range_error) |->
      (out_data.int_divider == 8'd0 && out_data.frac_value == 12'd0 &&
       out_data.achieved_khz == 23'd0 && out_data.int_flag == 1'b0 &&
       out_data.cp_linearity == 1'b0 && out_data.out_div_exp == 3'd0))
    else $error("range error result has nonzero fields");

  // in-band divider lands in the vco range and mode bits are complementary
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.range_error) |->
      (out_data.int_divider >= N_MIN && out_data.int_divider <= N_MAX &&
       out_data.cp_linearity != out_data.int_flag &&
       out_data.frac_one_bit != out_data.lock_detect_fn))
    else $error("in-band result out of range or mode bits inconsistent");

endmodule

// ===== sim/tb_pll_frequency_divider_plan_top.sv =====
// self-checking testbench for the pll divider planner: directed corners, then random requests
`timescale 1ns / 1ps

module tb_pll_frequency_divider_plan_top;
  import pfdp_pkg::*;

  typedef struct {
    pfdp_in_t    req;
    int unsigned idle_pct;
    bit          drain;
  } plan_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  pfdp_in_t  in_data = '0;
  logic      out_valid;
  pfdp_out_t out_data;

  plan_req_t   pending_reqs[$];
  pfdp_out_t   expected_plans[$];
  int unsigned mismatch_count = 0;

  pll_frequency_divider_plan_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // expected divider plan for one request
  function automatic pfdp_out_t plan_divider(input pfdp_in_t req);
    pfdp_out_t       plan;
    longint unsigned f, vco, n, rem, fr, ach;
    int unsigned     e;
    plan = '0;
    f = req.freq_khz;
    if (f < MIN_KHZ || f >= MAX_KHZ) begin
      plan.range_error = 1'b1;
      return plan;
    end
    // octave floors are 3 GHz halved, except the lowest band stops at MIN_KHZ
    e = 0;
    while (e < 7 && f < (64'd3000000 >> e)) e++;
    vco = f << e;
    n = vco / COMP_KHZ;
    rem = vco - n * COMP_KHZ;
    fr = (rem * FRAC_MOD * 2 + COMP_KHZ) / (2 * COMP_KHZ);
    if (req.int_mode) ach = (n * COMP_KHZ) >> e;
    else ach = ((n * FRAC_MOD + fr) * COMP_KHZ) / (64'(FRAC_MOD) << e);
    plan.out_div_exp    = 3'(e);
    plan.int_divider    = 8'(n);
    plan.frac_value     = 12'(fr);
    plan.int_flag       = req.int_mode;
    plan.cp_linearity   = ~req.int_mode;
    plan.lock_detect_fn = req.int_mode;
    plan.frac_one_bit   = ~req.int_mode;
    plan.achieved_khz   = 23'(ach);
    return plan;
  endfunction

  function automatic logic [22:0] pick_freq();
    int unsigned     sel, e;
    longint unsigned lo, hi;
    sel = $urandom_range(99);
    if (sel < 10) return 23'($urandom_range(MIN_KHZ - 1));
    if (sel < 20) return 23'($urandom_range(23'h7FFFFF, MAX_KHZ));
    e = $urandom_range(7);
    lo = (e == 7) ? 64'(MIN_KHZ) : (64'd3000000 >> e);
    hi = (64'(MAX_KHZ) >> e) - 1;
    if (sel < 26) return 23'(($urandom_range(1) != 0) ? hi : lo);
    return 23'($urandom_range(32'(hi), 32'(lo)));
  endfunction

  function automatic void queue_req(input logic [22:0] f, input logic im,
                                    input int unsigned idle_pct, input bit drain);
    plan_req_t item;
    item.req.freq_khz = f;
    item.req.int_mode = im;
    item.idle_pct = idle_pct;
    item.drain = drain;
    pending_reqs.push_back(item);
  endfunction

  function automatic void cmp_field(input string name, input longint unsigned exp_v,
                                    input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // driver: a transaction is taken when start is high and busy is low
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_plans.push_back(plan_divider(in_data));
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 &&
            !(pending_reqs[0].drain && expected_plans.size() > 0) &&
            $urandom_range(99) >= pending_reqs[0].idle_pct) begin
          in_data <= pending_reqs[0].req;
          start   <= 1'b1;
          void'(pending_reqs.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results cannot be held off, check each strobed one
  always @(posedge clk) begin
    pfdp_out_t want;
    if (rst_n && out_valid) begin
      if (expected_plans.size() == 0) begin
        $error("unexpected result: range_error %0d achieved_khz %0d",
               out_data.range_error, out_data.achieved_khz);
        mismatch_count++;
      end else begin
        want = expected_plans.pop_front();
        cmp_field("range_error", want.range_error, out_data.range_error);
        cmp_field("out_div_exp", want.out_div_exp, out_data.out_div_exp);
        cmp_field("int_divider", want.int_divider, out_data.int_divider);
        cmp_field("frac_value", want.frac_value, out_data.frac_value);
        cmp_field("int_flag", want.int_flag, out_data.int_flag);
        cmp_field("cp_linearity", want.cp_linearity, out_data.cp_linearity);
        cmp_field("lock_detect_fn", want.lock_detect_fn, out_data.lock_detect_fn);
        cmp_field("frac_one_bit", want.frac_one_bit, out_data.frac_one_bit);
        cmp_field("achieved_khz", want.achieved_khz, out_data.achieved_khz);
      end
    end
  end

  initial begin
    logic [22:0] corner_freqs[18];
    int unsigned phase_idle[4];
    corner_freqs = '{23'd0, 23'd23499, 23'd23500, 23'd46874, 23'd46875, 23'd93750,
                     23'd187500, 23'd375000, 23'd750000, 23'd1499999, 23'd1500000,
                     23'd3000000, 23'd5999999, 23'd6000000, 23'h7FFFFF,
                     // remainder rounds to full-scale fraction
                     23'd3071999,
                     // fraction exactly on a rounding tie, top and bottom band
                     23'd3073280, 23'd24010};
    phase_idle = '{0, 79, 0, 37};
    foreach (corner_freqs[i]) queue_req(corner_freqs[i], 1'(i % 2), 0, 1'b0);
    queue_req(23'd23500, 1'b1, 0, 1'b0);
    queue_req(23'd5999999, 1'b0, 0, 1'b0);
    queue_req(23'd3071999, 1'b1, 0, 1'b0);
    queue_req(23'd3073280, 1'b0, 0, 1'b0);
    for (int p = 0; p < 4; p++) begin
      // first transaction of each phase waits for the pipeline to drain
      for (int i = 0; i < 163; i++)
        queue_req(pick_freq(), 1'($urandom_range(1)), phase_idle[p], i == 0);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || start || expected_plans.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (expected_plans.size() > 0) begin
      $error("%0d expected results never arrived", expected_plans.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("pll_frequency_divider_plan_top regression: pass");
    end else begin
      $display("pll_frequency_divider_plan_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("pll_frequency_divider_plan_top regression: fail");
    $finish;
  end

endmodule
